// ===== design/pixel_bit_pattern_scanner_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the pixel bit pattern scanner
// Overlapping and next-cycle implication checks, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef PIXEL_BIT_PATTERN_SCANNER_TOP_ASSERT_SVH
`define PIXEL_BIT_PATTERN_SCANNER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define PBPS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pbps check failed");
`define PBPS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pbps check failed");
`else
`define PBPS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define PBPS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== design/pbps_pkg.sv =====
// ---------------------------------------------------------------------------
// Pixel bit pattern scanner package
// Shared widths, register indexes, patterns and the scan-to-emit request.
// ---------------------------------------------------------------------------
`default_nettype none

package pbps_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int COORD_W   = $clog2(MAX_DIM);
  localparam int DIM_W     = COORD_W + 1;
  localparam int CHAN_W    = 8;
  localparam int PIX_W     = 3 * CHAN_W;
  localparam int HIST_W    = 3;
  localparam int STREAM_W  = PIX_W + HIST_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [HIST_W:0] PAT_RISE = 4'b0010;
  localparam logic [HIST_W:0] PAT_FALL = 4'b1101;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [DIM_W-1:0]   dim_t;
  typedef logic [PIX_W-1:0]   pixel_t;

  typedef struct packed {
    pixel_t pix;
    coord_t x;
    coord_t y;
    pixel_t prev_pix;
    coord_t prev_x;
    coord_t prev_y;
  } hit_ctx_t;

  typedef struct packed {
    logic [PIX_W-1:0] mask;
    hit_ctx_t         ctx;
  } hit_req_t;

  // Zero acts as one, anything above the maximum acts as the maximum
  function automatic dim_t clamp_dim(input dim_t v);
    dim_t r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/pixel_bit_pattern_scanner_top.sv =====
// A pixel's warnings wait in the emitter's pending mask, then move to the output registers.
// Throughput: one pixel per cycle while pixels raise no warning; a pixel with warnings holds
// the input until its last is sent, one warning per cycle while the output is not stalled.
// Reset: clears width and height to 1, the bit history, position counters and
// any pending warnings; configuration writes are taken in every cycle out of reset.
// ---------------------------------------------------------------------------
// Pixel bit pattern scanner top level
// Scans the pixel bit stream for 0010 and 1101 and reports suspect bits.
// ---------------------------------------------------------------------------
`default_nettype none

`include "pixel_bit_pattern_scanner_top_assert.svh"

module pixel_bit_pattern_scanner_top import pbps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CHAN_W-1:0]    red,
  input  logic [CHAN_W-1:0]    green,
  input  logic [CHAN_W-1:0]    blue,
  input  logic                 frame_start,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COORD_W-1:0]   pixel_x,
  output logic [COORD_W-1:0]   pixel_y,
  output logic [CHAN_W-1:0]    warn_red,
  output logic [CHAN_W-1:0]    warn_green,
  output logic [CHAN_W-1:0]    warn_blue,
  output logic                 last_warning,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  logic     in_accept;
  hit_req_t req;

  assign cfg_ready = !rst;
  assign in_accept = in_valid && in_ready;

  pbps_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .in_accept   (in_accept),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .frame_start (frame_start),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req         (req)
  );

  pbps_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .take         (in_accept),
    .req_in       (req),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .warn_red     (warn_red),
    .warn_green   (warn_green),
    .warn_blue    (warn_blue),
    .last_warning (last_warning)
  );

  // a taken warning that is not the last of its pixel is followed at once
  `PBPS_ASSERT_NXT(a_burst_continues, clk, rst, out_valid && out_ready && !last_warning, out_valid)
  // hold new pixels while a stalled pixel still has warnings to send
  `PBPS_ASSERT_IMP(a_hold_input, clk, rst, out_valid && !out_ready && !last_warning, !in_ready)

endmodule

`default_nettype wire

// ===== design/pbps_scan.sv =====
// ---------------------------------------------------------------------------
// Pixel bit pattern scanner: scan stage
// Holds frame geometry, bit history and position; builds the hit mask.
// ---------------------------------------------------------------------------
`default_nettype none

module pbps_scan import pbps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_accept,
  input  logic [CHAN_W-1:0]    red,
  input  logic [CHAN_W-1:0]    green,
  input  logic [CHAN_W-1:0]    blue,
  input  logic                 frame_start,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  output hit_req_t             req
);

  dim_t              frame_width;
  dim_t              frame_height;
  logic [HIST_W-1:0] hist;
  logic              hist_valid;
  pixel_t            prev_pix;
  coord_t            prev_x;
  coord_t            prev_y;
  coord_t            column_count;
  coord_t            row_count;
  coord_t            column_next;
  coord_t            row_next;

  pixel_t              pix;
  logic [HIST_W-1:0]   hist_eff;
  logic                valid_eff;
  coord_t              col_eff;
  coord_t              row_eff;
  dim_t                w;
  dim_t                h;
  coord_t              cur_y;
  logic [STREAM_W-1:0] stream;
  logic [PIX_W-1:0]    mask;

  always_comb begin
    pix       = {red, green, blue};
    // drop history and position on the first pixel of a frame
    hist_eff  = frame_start ? '0 : hist;
    valid_eff = !frame_start && hist_valid;
    col_eff   = frame_start ? '0 : column_count;
    row_eff   = frame_start ? '0 : row_count;
    w         = clamp_dim(frame_width);
    h         = clamp_dim(frame_height);
    cur_y     = COORD_W'(h - DIM_W'(1) - {1'b0, row_eff});
    stream    = {hist_eff, pix};
    for (int j = 0; j < PIX_W; j++) begin
      mask[j] = (valid_eff || (j >= HIST_W)) &&
                ((stream[STREAM_W-1-j -: HIST_W+1] == PAT_RISE) ||
                 (stream[STREAM_W-1-j -: HIST_W+1] == PAT_FALL));
    end

    column_next = col_eff + COORD_W'(1);
    row_next    = row_eff;
    if (({1'b0, col_eff} + DIM_W'(1)) >= w) begin
      column_next = '0;
      if (({1'b0, row_eff} + DIM_W'(1)) >= h) row_next = '0;
      else row_next = row_eff + COORD_W'(1);
    end

    req.mask         = mask;
    req.ctx.pix      = pix;
    req.ctx.x        = col_eff;
    req.ctx.y        = cur_y;
    req.ctx.prev_pix = prev_pix;
    req.ctx.prev_x   = prev_x;
    req.ctx.prev_y   = prev_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_W'(1);
      frame_height <= DIM_W'(1);
      hist         <= '0;
      hist_valid   <= 1'b0;
      prev_pix     <= '0;
      prev_x       <= '0;
      prev_y       <= '0;
      column_count <= '0;
      row_count    <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  frame_width  <= cfg_data;
          REG_FRAME_HEIGHT: frame_height <= cfg_data;
          default: ;
        endcase
      end
      if (in_accept) begin
        hist         <= pix[HIST_W-1:0];
        hist_valid   <= 1'b1;
        prev_pix     <= pix;
        prev_x       <= col_eff;
        prev_y       <= cur_y;
        column_count <= column_next;
        row_count    <= row_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/pbps_emit.sv =====
// ---------------------------------------------------------------------------
// Pixel bit pattern scanner: warning emitter
// Holds one pixel's hit mask and sends its warnings in window order.
// ---------------------------------------------------------------------------
`default_nettype none

module pbps_emit import pbps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  hit_req_t          req_in,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output coord_t            pixel_x,
  output coord_t            pixel_y,
  output logic [CHAN_W-1:0] warn_red,
  output logic [CHAN_W-1:0] warn_green,
  output logic [CHAN_W-1:0] warn_blue,
  output logic              last_warning
);

  logic [PIX_W-1:0] pend_mask;
  hit_ctx_t         ctx;

  logic [PIX_W-1:0] lowest;
  logic [PIX_W-1:0] remaining;
  logic [PIX_W-1:0] flip;
  logic             load_out;
  coord_t           sel_x;
  coord_t           sel_y;
  pixel_t           sel_pix;

  always_comb begin
    lowest    = pend_mask & (~pend_mask + PIX_W'(1));
    remaining = pend_mask & ~lowest;
    load_out  = (pend_mask != '0) && (!out_valid || out_ready);
    // free once the last pending warning moves to the output; hold in reset
    in_ready  = !rst && ((pend_mask == '0) || (load_out && (remaining == '0)));

    flip = '0;
    for (int j = 1; j < PIX_W; j++) begin
      flip[PIX_W-j] = lowest[j];
    end

    // a hit on the first bit points at the blue LSB of the previous pixel
    if (lowest[0]) begin
      sel_x   = ctx.prev_x;
      sel_y   = ctx.prev_y;
      sel_pix = ctx.prev_pix ^ PIX_W'(1);
    end else begin
      sel_x   = ctx.x;
      sel_y   = ctx.y;
      sel_pix = ctx.pix ^ flip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_mask <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) pend_mask <= req_in.mask;
      else if (load_out) pend_mask <= remaining;
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) ctx <= req_in.ctx;
    if (load_out) begin
      pixel_x      <= sel_x;
      pixel_y      <= sel_y;
      warn_red     <= sel_pix[PIX_W-1 -: CHAN_W];
      warn_green   <= sel_pix[CHAN_W +: CHAN_W];
      warn_blue    <= sel_pix[CHAN_W-1:0];
      last_warning <= (remaining == '0);
    end
  end

endmodule

`default_nettype wire
